[rtl/rnp_pkg.sv]
package rnp_pkg;

    localparam int IntBitsDef  = 32;
    localparam int FracBitsDef = 16;

    localparam int BaseW = 5;
    localparam logic [BaseW-1:0] BaseReset = 5'd10;
    localparam logic [BaseW-1:0] BaseMin   = 5'd2;
    localparam logic [BaseW-1:0] BaseMax   = 5'd16;

    localparam logic [7:0] CharPoint  = 8'h2E;
    localparam logic [7:0] CharZero   = 8'h30;
    localparam logic [7:0] CharNine   = 8'h39;
    localparam logic [7:0] CharUpperA = 8'h41;
    localparam logic [7:0] CharUpperF = 8'h46;
    localparam logic [7:0] CharLowerA = 8'h61;
    localparam logic [7:0] CharLowerF = 8'h66;

    typedef struct packed {
        logic [7:0] character;
        logic       is_last;
    } t_req;

    typedef struct packed {
        logic [31:0] value_integer;
        logic [15:0] value_fraction;
        logic        is_valid;
        logic        overflowed;
    } t_res;

    typedef struct packed {
        logic       is_digit;
        logic       is_point;
        logic [3:0] digit;
    } t_dec;

    function automatic logic [31:0] recip_of(input logic [BaseW-1:0] base);
        logic [31:0] r;
        case (base)
            5'd2:    r = 32'd2147483648;
            5'd3:    r = 32'd1431655765;
            5'd4:    r = 32'd1073741824;
            5'd5:    r = 32'd858993459;
            5'd6:    r = 32'd715827882;
            5'd7:    r = 32'd613566756;
            5'd8:    r = 32'd536870912;
            5'd9:    r = 32'd477218588;
            5'd10:   r = 32'd429496729;
            5'd11:   r = 32'd390451572;
            5'd12:   r = 32'd357913941;
            5'd13:   r = 32'd330382099;
            5'd14:   r = 32'd306783378;
            5'd15:   r = 32'd286331153;
            5'd16:   r = 32'd268435456;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

[rtl/rnp_decode.sv]
module rnp_decode
    import rnp_pkg::*;
(
    input  logic [7:0] i_character,
    output t_dec       o_dec
);

    always_comb begin
        o_dec.is_digit = 1'b0;
        o_dec.is_point = (i_character == CharPoint);
        o_dec.digit    = 4'd0;
        if (i_character >= CharZero && i_character <= CharNine) begin
            o_dec.is_digit = 1'b1;
            o_dec.digit    = 4'(i_character - CharZero);
        end else if (i_character >= CharUpperA && i_character <= CharUpperF) begin
            o_dec.is_digit = 1'b1;
            o_dec.digit    = 4'(i_character - CharUpperA) + 4'd10;
        end else if (i_character >= CharLowerA && i_character <= CharLowerF) begin
            o_dec.is_digit = 1'b1;
            o_dec.digit    = 4'(i_character - CharLowerA) + 4'd10;
        end
    end

endmodule

[rtl/rnp_accum.sv]
module rnp_accum
    import rnp_pkg::*;
#(
    parameter int INT_BITS  = IntBitsDef,
    parameter int FRAC_BITS = FracBitsDef
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic             i_last,
    input  t_dec             i_dec,
    input  logic [BaseW-1:0] i_base,
    output t_res             o_res
);

    localparam int ProdW     = INT_BITS + BaseW;
    localparam int FracShift = 32 - FRAC_BITS;

    logic [INT_BITS-1:0] r_int, n_int;
    logic [31:0]         r_frac, n_frac;
    logic [31:0]         r_weight, n_weight;
    logic                r_point, n_point;
    logic                r_invalid, n_invalid;
    logic                r_ovf, n_ovf;

    logic [BaseW-1:0] base;
    logic [31:0]      recip;
    logic             legal;
    logic [ProdW-1:0] int_prod;
    logic [36:0]      frac_sum;
    logic [63:0]      weight_prod;
    logic [63:0]      int_ext;
    logic [31:0]      frac_sh;

    always_comb begin
        if (i_base < BaseMin) begin
            base = BaseMin;
        end else if (i_base > BaseMax) begin
            base = BaseMax;
        end else begin
            base = i_base;
        end
    end

    assign recip       = recip_of(base);
    assign legal       = i_dec.is_digit && (BaseW'(i_dec.digit) < base);
    assign int_prod    = ProdW'(r_int) * ProdW'(base) + ProdW'(i_dec.digit);
    assign frac_sum    = 37'(r_frac) + 37'(r_weight) * 37'(i_dec.digit);
    assign weight_prod = 64'(r_weight) * 64'(recip);

    always_comb begin
        n_int     = r_int;
        n_frac    = r_frac;
        n_weight  = r_weight;
        n_point   = r_point;
        n_invalid = r_invalid;
        n_ovf     = r_ovf;
        if (i_dec.is_point) begin
            if (r_point) begin
                n_invalid = 1'b1;
            end else begin
                n_point  = 1'b1;
                n_weight = recip;
            end
        end else if (!legal) begin
            n_invalid = 1'b1;
        end else if (!r_point) begin
            if (r_ovf || (int_prod[ProdW-1:INT_BITS] != '0)) begin
                n_ovf = 1'b1;
                n_int = '1;
            end else begin
                n_int = int_prod[INT_BITS-1:0];
            end
        end else begin
            n_frac   = (frac_sum[36:32] != '0) ? 32'hFFFF_FFFF : frac_sum[31:0];
            n_weight = weight_prod[63:32];
        end
    end

    assign int_ext = 64'(n_int);
    assign frac_sh = n_frac >> FracShift;

    always_comb begin
        o_res.value_integer  = int_ext[31:0];
        o_res.value_fraction = frac_sh[15:0];
        o_res.is_valid       = 1'b1;
        o_res.overflowed     = n_ovf;
        if (n_invalid) begin
            o_res = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_last)) begin
            r_int     <= '0;
            r_frac    <= '0;
            r_weight  <= '0;
            r_point   <= 1'b0;
            r_invalid <= 1'b0;
            r_ovf     <= 1'b0;
        end else if (i_fire) begin
            r_int     <= n_int;
            r_frac    <= n_frac;
            r_weight  <= n_weight;
            r_point   <= n_point;
            r_invalid <= n_invalid;
            r_ovf     <= n_ovf;
        end
    end

endmodule

[rtl/radix_number_parser_top.sv]
// Each request is held in the input register; results are held in the result register.
// Throughput: one character per cycle, but a last character waits while the result register
// is full; set by the accumulator update, its longest path the 32x32 place-weight multiply.
// Only a character marked last produces a result.
// Reset (synchronous, active low) clears all accumulators and sets the base to 10.
module radix_number_parser_top
    import rnp_pkg::*;
#(
    parameter int INT_BITS  = IntBitsDef,
    parameter int FRAC_BITS = FracBitsDef
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  t_req             i_req,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output t_res             o_res,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [BaseW-1:0] i_cfg_data
);

    logic             r_req_valid;
    t_req             r_req;
    logic             r_res_valid;
    t_res             r_res;
    logic [BaseW-1:0] r_base;

    logic res_free;
    logic fire;
    t_dec dec;
    t_res res;

    assign res_free    = !r_res_valid || i_res_ready;
    assign fire        = r_req_valid && (!r_req.is_last || res_free);
    assign o_req_ready = !r_req_valid || fire;
    assign o_cfg_ready = 1'b1;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    rnp_decode u_decode (
        .i_character (r_req.character),
        .o_dec       (dec)
    );

    rnp_accum #(
        .INT_BITS  (INT_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_last  (r_req.is_last),
        .i_dec   (dec),
        .i_base  (r_base),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_res_valid <= 1'b0;
            r_base      <= BaseReset;
        end else begin
            if (o_req_ready) begin
                r_req_valid <= i_req_valid;
            end
            if (fire && r_req.is_last) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_base <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_req_ready && i_req_valid) begin
            r_req <= i_req;
        end
        if (fire && r_req.is_last) begin
            r_res <= res;
        end
    end

endmodule

[tb/tb_radix_number_parser_top.sv]
module tb_radix_number_parser_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rnp_pkg::*;

    localparam logic [63:0] IntMax  = (64'd1 << IntBitsDef) - 64'd1;
    localparam logic [63:0] FracMax = 64'hFFFF_FFFF;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_req_valid = 1'b0;
    logic             o_req_ready;
    t_req             i_req       = '0;
    logic             o_res_valid;
    logic             i_res_ready = 1'b0;
    t_res             o_res;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [BaseW-1:0] i_cfg_data  = '0;

    t_req char_queue[$];
    t_res expected_results[$];

    int send_gap_pct   = 19;
    int recv_stall_pct = 80;
    int fail_count     = 0;

    logic [BaseW-1:0] cur_base;
    logic [63:0]      acc_int;
    logic [31:0]      acc_frac;
    logic [31:0]      weight;
    logic             got_point;
    logic             got_bad;
    logic             got_ovf;

    radix_number_parser_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int clamp_base(input logic [BaseW-1:0] b);
        if (b < BaseMin) begin
            return int'(BaseMin);
        end
        if (b > BaseMax) begin
            return int'(BaseMax);
        end
        return int'(b);
    endfunction

    function automatic int digit_value(input logic [7:0] ch);
        if (ch >= CharZero && ch <= CharNine) begin
            return int'(ch - CharZero);
        end
        if (ch >= CharUpperA && ch <= CharUpperF) begin
            return int'(ch - CharUpperA) + 10;
        end
        if (ch >= CharLowerA && ch <= CharLowerF) begin
            return int'(ch - CharLowerA) + 10;
        end
        return -1;
    endfunction

    function automatic void clear_number();
        acc_int   = '0;
        acc_frac  = '0;
        weight    = '0;
        got_point = 1'b0;
        got_bad   = 1'b0;
        got_ovf   = 1'b0;
    endfunction

    function automatic void parse_char(input t_req r);
        logic [63:0] b;
        logic [63:0] recip;
        logic [63:0] limit;
        logic [63:0] total;
        int          d;
        t_res        res;
        b     = 64'(clamp_base(cur_base));
        recip = (64'd1 << 32) / b;
        d     = digit_value(r.character);
        if (r.character == CharPoint) begin
            if (got_point) begin
                got_bad = 1'b1;
            end else begin
                got_point = 1'b1;
                weight    = recip[31:0];
            end
        end else if (d < 0 || d >= int'(b)) begin
            got_bad = 1'b1;
        end else if (!got_point) begin
            limit = (IntMax - 64'(d)) / b;
            if (got_ovf || acc_int > limit) begin
                got_ovf = 1'b1;
                acc_int = IntMax;
            end else begin
                acc_int = acc_int * b + 64'(d);
            end
        end else begin
            total = 64'(acc_frac) + 64'(weight) * 64'(d);
            if (total > FracMax) begin
                total = FracMax;
            end
            acc_frac = total[31:0];
            total    = (64'(weight) * recip) >> 32;
            weight   = total[31:0];
        end
        if (r.is_last) begin
            res = '0;
            if (!got_bad) begin
                res.value_integer  = acc_int[31:0];
                res.value_fraction = acc_frac[31:16];
                res.is_valid       = 1'b1;
                res.overflowed     = got_ovf;
            end
            expected_results.push_back(res);
            clear_number();
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_req_valid <= 1'b0;
            cur_base = BaseReset;
            clear_number();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                cur_base = i_cfg_data;
            end
            if (i_req_valid && o_req_ready) begin
                parse_char(i_req);
            end
            if (!i_req_valid || o_req_ready) begin
                if (char_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    i_req       <= char_queue.pop_front();
                    i_req_valid <= 1'b1;
                end else begin
                    i_req_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_res want;
        if (!i_rst_n) begin
            i_res_ready <= 1'b0;
        end else begin
            if (o_res_valid && i_res_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: %p", o_res);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_res.value_integer !== want.value_integer) begin
                        $error("value_integer: expected %0d, got %0d",
                               want.value_integer, o_res.value_integer);
                        fail_count++;
                    end
                    if (o_res.value_fraction !== want.value_fraction) begin
                        $error("value_fraction: expected %0d, got %0d",
                               want.value_fraction, o_res.value_fraction);
                        fail_count++;
                    end
                    if (o_res.is_valid !== want.is_valid) begin
                        $error("is_valid: expected %0d, got %0d",
                               want.is_valid, o_res.is_valid);
                        fail_count++;
                    end
                    if (o_res.overflowed !== want.overflowed) begin
                        $error("overflowed: expected %0d, got %0d",
                               want.overflowed, o_res.overflowed);
                        fail_count++;
                    end
                end
            end
            i_res_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [7:0] digit_char(input int d);
        if (d < 10) begin
            return CharZero + 8'(d);
        end
        if ($urandom_range(1) == 1) begin
            return CharUpperA + 8'(d - 10);
        end
        return CharLowerA + 8'(d - 10);
    endfunction

    function automatic void push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            char_queue.push_back('{character: s[i], is_last: (i == s.len() - 1)});
        end
    endfunction

    function automatic int add_number(input int b);
        logic [7:0] text[$];
        int         n_int;
        int         n_frac;
        int         kind;
        int         pos;
        int         i;
        n_int  = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(6);
        n_frac = ($urandom_range(9) == 0) ? $urandom_range(36, 8) : $urandom_range(4);
        for (i = 0; i < n_int; i++) begin
            text.push_back(digit_char($urandom_range(b - 1)));
        end
        if (n_frac > 0 || $urandom_range(3) == 0) begin
            text.push_back(CharPoint);
            for (i = 0; i < n_frac; i++) begin
                text.push_back(digit_char($urandom_range(b - 1)));
            end
        end
        kind = $urandom_range(99);
        pos  = $urandom_range(text.size());
        if (kind >= 94) begin
            text.insert(pos, 8'($urandom_range(255)));
        end else if (kind >= 88) begin
            text.insert(pos, CharPoint);
        end else if (kind >= 82) begin
            text.insert(pos, (b < 16) ? digit_char($urandom_range(15, b))
                                      : CharLowerF + 8'd1);
        end
        if (text.size() == 0) begin
            text.push_back(digit_char($urandom_range(b - 1)));
        end
        for (i = 0; i < text.size(); i++) begin
            char_queue.push_back('{character: text[i], is_last: (i == text.size() - 1)});
        end
        return text.size();
    endfunction

    task automatic wait_drained();
        while (char_queue.size() != 0 || i_req_valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_base(input logic [BaseW-1:0] b);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= b;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [BaseW-1:0] bases[12];
        int               p;
        int               sent;
        bases = '{5'd16, 5'd2, 5'd0, 5'd31, 5'd17, 5'd1,
                  5'd8, 5'd10, 5'd3, 5'd7, 5'd12, 5'd15};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_base(BaseReset);
        push_text("0");
        push_text(".");
        push_text("f");
        push_text("9.5");
        push_text("..");
        push_text("99999999999");
        char_queue.push_back('{character: 8'hFF, is_last: 1'b1});
        char_queue.push_back('{character: 8'h00, is_last: 1'b1});

        for (p = 0; p < 12; p++) begin
            write_base(bases[p]);
            if (p == 4) begin
                send_gap_pct   = 80;
                recv_stall_pct = 19;
            end else if (p == 8) begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            sent = 0;
            while (sent < 90) begin
                sent += add_number(clamp_base(bases[p]));
            end
        end
        wait_drained();
        repeat (4) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[filelist.f]
rtl/rnp_pkg.sv
rtl/rnp_decode.sv
rtl/rnp_accum.sv
rtl/radix_number_parser_top.sv
tb/tb_radix_number_parser_top.sv
